// File: design/fca_pkg.sv
// Shared constants and types for the FAT chain allocator.
// No dependencies; used by fca_table and fat_chain_allocator.
package fca_pkg;

  localparam int NUM_BLOCKS       = 1024;
  localparam int FIRST_DATA_BLOCK = 7;
  localparam int BLK_W            = $clog2(NUM_BLOCKS);
  localparam int CNT_W            = BLK_W + 1;
  localparam int LINK_W           = 16;

  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

  localparam logic [2:0] MODE_ALLOC     = 3'd0;
  localparam logic [2:0] MODE_FREE      = 3'd1;
  localparam logic [2:0] MODE_TRUNC     = 3'd2;
  localparam logic [2:0] MODE_SEEK_EXT  = 3'd3;
  localparam logic [2:0] MODE_SEEK_ONLY = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_ENDED   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_FEND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_FREE,
    OP_TRUNC,
    OP_SEEK,
    OP_SCAN
  } op_t;

  typedef struct packed {
    logic              en;
    logic [BLK_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } wr_req_t;

endpackage

// File: design/fca_table.sv
// Link table storage: one write port, one registered read port.
// Depends on fca_pkg.
module fca_table (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [fca_pkg::BLK_W-1:0]     rd_addr,
  output logic [fca_pkg::LINK_W-1:0]    rd_data,
  input  fca_pkg::wr_req_t              wr
);

  logic [fca_pkg::LINK_W-1:0] mem [fca_pkg::NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/fat_chain_allocator.sv
// FAT chain allocator: request channel in_*, result channel out_*, one
// result per request. Depends on fca_pkg and fca_table.
//
// Usage: a request (mode, start_block, block_steps) is taken when in_valid
// and in_ready are high; in_ready is high whenever the sequencer is idle,
// also while the previous result waits in the output register.
// Timing is data dependent, all set by the single link table port:
//   each table entry visited takes a read state, then an evaluate/write state;
//   allocate: one such visit per entry scanned from the lowest-free hint;
//   free chain / truncate: one visit per chain block;
//   seek: one visit per step, plus the scan and an end-mark state per appended block;
//   then the done state hands the result to the output register.
// A full table answers allocation with no scan once the hint has run out.
// After reset the table is cleared one entry per cycle (all 1024 entries) with
// in_ready low. A stalled receiver (out_ready low) holds the result in the
// output register; one more request may be worked on, then the block waits.
module fat_chain_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_mode,
  input  logic [fca_pkg::BLK_W-1:0]  in_start_block,
  input  logic [fca_pkg::BLK_W-1:0]  in_block_steps,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fca_pkg::BLK_W-1:0]  out_block,
  output logic [1:0]                 out_status
);

  localparam int BW = fca_pkg::BLK_W;
  localparam int CW = fca_pkg::CNT_W;
  localparam int LW = fca_pkg::LINK_W;

  fca_pkg::state_t state_r, state_nxt;
  fca_pkg::op_t    op_r, op_nxt;
  logic [2:0]      mode_r, mode_nxt;
  logic [BW-1:0]   cur_r, cur_nxt;
  logic [BW-1:0]   steps_r, steps_nxt;
  logic [BW-1:0]   cnt_r, cnt_nxt;
  logic [BW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic [CW-1:0]   hint_r, hint_nxt;
  logic [BW-1:0]   res_blk_r, res_blk_nxt;
  logic [1:0]      res_stat_r, res_stat_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [BW-1:0]   out_block_r, out_block_nxt;
  logic [1:0]      out_status_r, out_status_nxt;

  logic            rd_en;
  logic [BW-1:0]   rd_addr;
  logic [LW-1:0]   rd_data;
  fca_pkg::wr_req_t wr;
  logic            q_next;
  logic            bad_start;

  fca_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign in_ready   = (state_r == fca_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_block  = out_block_r;
  assign out_status = out_status_r;

  // link points at another block of the chain
  assign q_next = (rd_data != fca_pkg::LINK_FREE) && (rd_data != fca_pkg::LINK_END) &&
                  (rd_data < LW'(fca_pkg::NUM_BLOCKS));
  assign bad_start = ({1'b0, in_start_block} >= CW'(fca_pkg::NUM_BLOCKS));

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    mode_nxt       = mode_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    hint_nxt       = hint_r;
    res_blk_nxt    = res_blk_r;
    res_stat_nxt   = res_stat_r;
    out_block_nxt  = out_block_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    rd_en          = 1'b0;
    rd_addr        = (op_r == fca_pkg::OP_SCAN) ? scan_r[BW-1:0] : cur_r;
    wr             = '0;

    case (state_r)
      fca_pkg::ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        wr.data = fca_pkg::LINK_FREE;
        clr_nxt = clr_r + BW'(1);
        if (clr_r == BW'(fca_pkg::NUM_BLOCKS - 1)) begin
          state_nxt = fca_pkg::ST_IDLE;
        end
      end

      fca_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt     = in_mode;
          cur_nxt      = in_start_block;
          steps_nxt    = in_block_steps;
          cnt_nxt      = '0;
          res_blk_nxt  = '0;
          res_stat_nxt = fca_pkg::STAT_OK;
          if (in_mode == fca_pkg::MODE_ALLOC) begin
            op_nxt   = fca_pkg::OP_SCAN;
            scan_nxt = hint_r;
            if (hint_r >= CW'(fca_pkg::NUM_BLOCKS)) begin
              res_stat_nxt = fca_pkg::STAT_NO_FREE;
              state_nxt    = fca_pkg::ST_DONE;
            end else begin
              state_nxt = fca_pkg::ST_RD;
            end
          end else if (in_mode > fca_pkg::MODE_SEEK_ONLY) begin
            state_nxt = fca_pkg::ST_DONE;
          end else if (bad_start) begin
            res_stat_nxt = fca_pkg::STAT_ENDED;
            state_nxt    = fca_pkg::ST_DONE;
          end else if (in_mode == fca_pkg::MODE_FREE) begin
            op_nxt    = fca_pkg::OP_FREE;
            state_nxt = fca_pkg::ST_RD;
          end else if (in_mode == fca_pkg::MODE_TRUNC) begin
            op_nxt    = fca_pkg::OP_TRUNC;
            state_nxt = fca_pkg::ST_RD;
          end else begin
            op_nxt = fca_pkg::OP_SEEK;
            if (in_block_steps == '0) begin
              res_blk_nxt = in_start_block;
              state_nxt   = fca_pkg::ST_DONE;
            end else begin
              state_nxt = fca_pkg::ST_RD;
            end
          end
        end
      end

      fca_pkg::ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = fca_pkg::ST_EV;
      end

      fca_pkg::ST_EV: begin
        case (op_r)
          fca_pkg::OP_FREE: begin
            wr.en   = 1'b1;
            wr.addr = cur_r;
            wr.data = fca_pkg::LINK_FREE;
            if (cur_r >= BW'(fca_pkg::FIRST_DATA_BLOCK) && {1'b0, cur_r} < hint_r) begin
              hint_nxt = {1'b0, cur_r};
            end
            // walk is bounded to NUM_BLOCKS entries
            if (!q_next || cnt_r == BW'(fca_pkg::NUM_BLOCKS - 1)) begin
              state_nxt = fca_pkg::ST_DONE;
            end else begin
              cur_nxt   = rd_data[BW-1:0];
              cnt_nxt   = cnt_r + BW'(1);
              state_nxt = fca_pkg::ST_RD;
            end
          end

          fca_pkg::OP_TRUNC: begin
            wr.en   = 1'b1;
            wr.addr = cur_r;
            wr.data = fca_pkg::LINK_END;
            if (q_next) begin
              cur_nxt   = rd_data[BW-1:0];
              cnt_nxt   = '0;
              op_nxt    = fca_pkg::OP_FREE;
              state_nxt = fca_pkg::ST_RD;
            end else begin
              state_nxt = fca_pkg::ST_DONE;
            end
          end

          fca_pkg::OP_SEEK: begin
            if (q_next) begin
              cur_nxt   = rd_data[BW-1:0];
              steps_nxt = steps_r - BW'(1);
              if (steps_r == BW'(1)) begin
                res_blk_nxt = rd_data[BW-1:0];
                state_nxt   = fca_pkg::ST_DONE;
              end else begin
                state_nxt = fca_pkg::ST_RD;
              end
            end else if (mode_r == fca_pkg::MODE_SEEK_ONLY) begin
              res_blk_nxt  = cur_r;
              res_stat_nxt = fca_pkg::STAT_ENDED;
              state_nxt    = fca_pkg::ST_DONE;
            end else begin
              // chain end: look for a block to append
              op_nxt   = fca_pkg::OP_SCAN;
              scan_nxt = hint_r;
              if (hint_r >= CW'(fca_pkg::NUM_BLOCKS)) begin
                res_blk_nxt  = cur_r;
                res_stat_nxt = fca_pkg::STAT_NO_FREE;
                state_nxt    = fca_pkg::ST_DONE;
              end else begin
                state_nxt = fca_pkg::ST_RD;
              end
            end
          end

          fca_pkg::OP_SCAN: begin
            if (rd_data == fca_pkg::LINK_FREE) begin
              if (mode_r == fca_pkg::MODE_ALLOC) begin
                wr.en       = 1'b1;
                wr.addr     = scan_r[BW-1:0];
                wr.data     = fca_pkg::LINK_END;
                hint_nxt    = scan_r + CW'(1);
                res_blk_nxt = scan_r[BW-1:0];
                state_nxt   = fca_pkg::ST_DONE;
              end else begin
                // link first, end mark next cycle (same block case ends as END)
                wr.en     = 1'b1;
                wr.addr   = cur_r;
                wr.data   = LW'(scan_r);
                state_nxt = fca_pkg::ST_FEND;
              end
            end else if (scan_r == CW'(fca_pkg::NUM_BLOCKS - 1)) begin
              hint_nxt     = CW'(fca_pkg::NUM_BLOCKS);
              res_blk_nxt  = (mode_r == fca_pkg::MODE_ALLOC) ? '0 : cur_r;
              res_stat_nxt = fca_pkg::STAT_NO_FREE;
              state_nxt    = fca_pkg::ST_DONE;
            end else begin
              scan_nxt  = scan_r + CW'(1);
              state_nxt = fca_pkg::ST_RD;
            end
          end

          default: begin
            state_nxt = fca_pkg::ST_DONE;
          end
        endcase
      end

      fca_pkg::ST_FEND: begin
        wr.en     = 1'b1;
        wr.addr   = scan_r[BW-1:0];
        wr.data   = fca_pkg::LINK_END;
        hint_nxt  = scan_r + CW'(1);
        cur_nxt   = scan_r[BW-1:0];
        steps_nxt = steps_r - BW'(1);
        op_nxt    = fca_pkg::OP_SEEK;
        if (steps_r == BW'(1)) begin
          res_blk_nxt = scan_r[BW-1:0];
          state_nxt   = fca_pkg::ST_DONE;
        end else begin
          state_nxt = fca_pkg::ST_RD;
        end
      end

      fca_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_block_nxt  = res_blk_r;
          out_status_nxt = res_stat_r;
          state_nxt      = fca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fca_pkg::ST_CLEAR;
      op_r        <= fca_pkg::OP_FREE;
      clr_r       <= '0;
      hint_r      <= CW'(fca_pkg::FIRST_DATA_BLOCK);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    cnt_r        <= cnt_nxt;
    scan_r       <= scan_nxt;
    res_blk_r    <= res_blk_nxt;
    res_stat_r   <= res_stat_nxt;
    out_block_r  <= out_block_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
